### sv/polynomial_arith_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial arithmetic engine
// Clocked, reset-gated property checks shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_ARITH_ENGINE_ASSERT_SVH
`define POLYNOMIAL_ARITH_ENGINE_ASSERT_SVH

// Property must hold at every rising edge outside reset.
`define PAE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define PAE_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### sv/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg
// Shared widths, request codes and defaults of the polynomial engine.
// ----------------------------------------------------------------------------
package pae_pkg;

  // Default number of coefficients per operand
  localparam int unsigned MAX_TERMS_DEF = 128;

  // Fixed field widths
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned TIDX_W = 8;
  localparam int unsigned COEF_W = 32;

  // Request codes; code 7 is unassigned
  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE_A = 3'd0,
    REQ_WRITE_B = 3'd1,
    REQ_ADD     = 3'd2,
    REQ_SUB     = 3'd3,
    REQ_MUL     = 3'd4,
    REQ_READ    = 3'd5,
    REQ_CLEAR   = 3'd6
  } req_e;

  typedef logic [COEF_W-1:0] coef_t;

endpackage

### sv/pae_if.sv
// ----------------------------------------------------------------------------
// pae request and response channels
// Valid/ready stream interfaces carrying one request or one response a beat.
// ----------------------------------------------------------------------------

// Request channel
interface pae_req_if;
  logic                               valid;
  logic                               ready;
  logic [pae_pkg::REQ_W-1:0]          req_type;
  logic [pae_pkg::TIDX_W-1:0]         term_index;
  logic signed [pae_pkg::COEF_W-1:0]  coef_value;

  modport source (output valid, req_type, term_index, coef_value, input ready);
  modport sink   (input valid, req_type, term_index, coef_value, output ready);
endinterface

// Response channel
interface pae_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [pae_pkg::COEF_W-1:0]  read_value;
  logic                               status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

### sv/polynomial_arith_engine.sv
// ----------------------------------------------------------------------------
// polynomial_arith_engine
// Dense polynomial store with add, subtract and convolution multiply.
// ----------------------------------------------------------------------------
// Holds operands A and B (MAX_TERMS coefficients each) and a result store of
// 2*MAX_TERMS-1 coefficients, all in single-port-write RAMs. Every request
// beat produces exactly one response beat. Work per request, M = MAX_TERMS:
// add and subtract step through 2*M-1 result terms, one result term a cycle;
// multiply steps through all M*M coefficient pairs, one pair a cycle
// through the single multiply-accumulate unit (one A read, one B read per
// cycle); clear operands steps through M rows, one RAM row a cycle. After
// reset the block runs a clearing pass over all stores and holds ready low
// meanwhile. A finished response sits in an output register, so the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
`include "polynomial_arith_engine_assert.svh"

module polynomial_arith_engine #(
  parameter int unsigned MAX_TERMS = pae_pkg::MAX_TERMS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pae_req_if.sink   req_i,
  pae_rsp_if.source rsp_o
);

  localparam int unsigned RES_TERMS = 2 * MAX_TERMS - 1;
  localparam int unsigned IDX_W     = $clog2(MAX_TERMS);
  localparam int unsigned RES_W     = $clog2(RES_TERMS);
  localparam int unsigned CW        = pae_pkg::COEF_W;

  localparam logic [RES_W-1:0] K_LAST   = RES_W'(RES_TERMS - 1);
  localparam logic [RES_W-1:0] M_RES    = RES_W'(MAX_TERMS);
  localparam logic [RES_W-1:0] M_LASTR  = RES_W'(MAX_TERMS - 1);
  localparam logic [IDX_W-1:0] M_LASTI  = IDX_W'(MAX_TERMS - 1);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Sequencer state
  state_e             state_q;
  logic               clr_all_q;
  logic [RES_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   j_q;
  pae_pkg::req_e      op_q;
  pae_pkg::coef_t     res_data_q;
  logic               res_status_q;
  logic               out_valid_q;
  pae_pkg::coef_t     out_data_q;
  logic               out_status_q;

  // Pipeline
  logic               v1_q, last1_q, zero1_q;
  logic [RES_W-1:0]   k1_q;
  logic               v2_q, last2_q;
  logic [RES_W-1:0]   k2_q;
  pae_pkg::coef_t     alu_q, alu_d;
  pae_pkg::coef_t     acc_q, acc_sum;

  // Memories
  pae_pkg::coef_t     mem_a_q [MAX_TERMS];
  pae_pkg::coef_t     mem_b_q [MAX_TERMS];
  pae_pkg::coef_t     mem_r_q [RES_TERMS];
  pae_pkg::coef_t     rd_a_q, rd_b_q, rd_r_q;

  logic               a_we, b_we, r_we;
  logic [IDX_W-1:0]   ab_waddr, a_raddr, b_raddr;
  pae_pkg::coef_t     ab_wdata, r_wdata;
  logic [RES_W-1:0]   r_waddr, r_raddr;

  // Request decode
  logic               accept, in_range_w, in_range_r, clr_ab, run_req;
  pae_pkg::req_e      req;

  // Run issue
  logic               k_ge_m, last_pair, issue;
  logic [IDX_W-1:0]   jhi, jlo_next;
  logic [RES_W-1:0]   k_next;

  assign accept      = req_i.valid && req_i.ready;
  assign req         = pae_pkg::req_e'(req_i.req_type);
  assign in_range_w  = 32'(req_i.term_index) < MAX_TERMS;
  assign in_range_r  = 32'(req_i.term_index) < RES_TERMS;
  assign req_i.ready = (state_q == ST_IDLE);
  assign run_req     = accept &&
                       (req inside {pae_pkg::REQ_ADD, pae_pkg::REQ_SUB, pae_pkg::REQ_MUL});

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = $signed(out_data_q);
  assign rsp_o.status     = out_status_q;

  // Pair walk: for term k, j runs from max(0,k-M+1) to min(k,M-1)
  assign k_ge_m    = cnt_q >= M_RES;
  assign jhi       = k_ge_m ? M_LASTI : IDX_W'(cnt_q);
  assign last_pair = (op_q != pae_pkg::REQ_MUL) || (j_q == jhi);
  assign k_next    = cnt_q + RES_W'(1);
  assign jlo_next  = (k_next >= M_RES) ? IDX_W'(k_next - M_LASTR) : '0;
  assign issue     = (state_q == ST_RUN);

  always_comb begin
    if (op_q == pae_pkg::REQ_MUL) begin
      a_raddr = j_q;
      b_raddr = IDX_W'(cnt_q - RES_W'(j_q));
    end else begin
      a_raddr = IDX_W'(cnt_q);
      b_raddr = IDX_W'(cnt_q);
    end
  end

  // Memory write ports
  assign clr_ab   = (state_q == ST_CLR) && (cnt_q < M_RES);
  assign ab_waddr = (state_q == ST_CLR) ? IDX_W'(cnt_q) : IDX_W'(req_i.term_index);
  assign ab_wdata = (state_q == ST_CLR) ? '0 : pae_pkg::coef_t'(req_i.coef_value);
  assign a_we     = clr_ab || (accept && req == pae_pkg::REQ_WRITE_A && in_range_w);
  assign b_we     = clr_ab || (accept && req == pae_pkg::REQ_WRITE_B && in_range_w);

  assign acc_sum  = acc_q + alu_q;
  assign r_we     = ((state_q == ST_CLR) && clr_all_q) || (v2_q && last2_q);
  assign r_waddr  = (state_q == ST_CLR) ? cnt_q : k2_q;
  assign r_wdata  = (state_q == ST_CLR) ? '0 : acc_sum;
  assign r_raddr  = RES_W'(req_i.term_index);

  // Operand and result RAMs, registered read
  always_ff @(posedge clk_i) begin
    if (a_we) mem_a_q[ab_waddr] <= ab_wdata;
    rd_a_q <= mem_a_q[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) mem_b_q[ab_waddr] <= ab_wdata;
    rd_b_q <= mem_b_q[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) mem_r_q[r_waddr] <= r_wdata;
    rd_r_q <= mem_r_q[r_raddr];
  end

  // Shared arithmetic unit: multiply, add or subtract one pair
  always_comb begin
    case (op_q)
      pae_pkg::REQ_MUL: alu_d = CW'(rd_a_q * rd_b_q);
      pae_pkg::REQ_SUB: alu_d = rd_a_q - rd_b_q;
      default:          alu_d = rd_a_q + rd_b_q;
    endcase
    if (zero1_q) alu_d = '0;
  end

  // Pipeline control and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (v2_q) acc_q <= last2_q ? '0 : acc_sum;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    last1_q <= last_pair;
    zero1_q <= (op_q != pae_pkg::REQ_MUL) && k_ge_m;
    k1_q    <= cnt_q;
    last2_q <= last1_q;
    k2_q    <= k1_q;
    alu_q   <= alu_d;
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      clr_all_q    <= 1'b1;
      cnt_q        <= '0;
      j_q          <= '0;
      op_q         <= pae_pkg::REQ_ADD;
      res_data_q   <= '0;
      res_status_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= 1'b0;
    end else begin
      // Output register: load a finished beat, or retire the one taken
      if ((state_q == ST_DONE) && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q  <= 1'b1;
        out_data_q   <= res_data_q;
        out_status_q <= res_status_q;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLR: begin
          if (cnt_q == (clr_all_q ? K_LAST : M_LASTR)) begin
            cnt_q     <= '0;
            clr_all_q <= 1'b0;
            state_q   <= clr_all_q ? ST_IDLE : ST_DONE;
          end else begin
            cnt_q <= cnt_q + RES_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_data_q <= '0;
            cnt_q      <= '0;
            j_q        <= '0;
            case (req)
              pae_pkg::REQ_WRITE_A, pae_pkg::REQ_WRITE_B: begin
                res_status_q <= !in_range_w;
                state_q      <= ST_DONE;
              end
              pae_pkg::REQ_ADD, pae_pkg::REQ_SUB, pae_pkg::REQ_MUL: begin
                res_status_q <= 1'b0;
                op_q         <= req;
                state_q      <= ST_RUN;
              end
              pae_pkg::REQ_READ: begin
                res_status_q <= !in_range_r;
                state_q      <= in_range_r ? ST_RD : ST_DONE;
              end
              pae_pkg::REQ_CLEAR: begin
                res_status_q <= 1'b0;
                clr_all_q    <= 1'b0;
                state_q      <= ST_CLR;
              end
              default: begin
                res_status_q <= 1'b0;
                state_q      <= ST_DONE;
              end
            endcase
          end
        end
        ST_RD: begin
          res_data_q <= rd_r_q;
          state_q    <= ST_DONE;
        end
        ST_RUN: begin
          // one pair a beat; step to the next term on its last pair
          if (last_pair) begin
            if (cnt_q == K_LAST) begin
              state_q <= ST_DRAIN;
            end else begin
              cnt_q <= k_next;
              j_q   <= jlo_next;
            end
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || rsp_o.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `PAE_ASSERT(a_pipe_order, clk_i, rst_ni, v2_q |-> $past(v1_q), "stage 2 beat without stage 1")
  `PAE_ASSERT(a_acc_clean, clk_i, rst_ni, run_req |-> (acc_q == '0), "accumulator not clear at run start")
  `PAE_NEVER(a_wr_collide, clk_i, rst_ni, (state_q == ST_CLR) && v2_q, "datapath write during clear sweep")
  `PAE_NEVER(a_rdy_sweep, clk_i, rst_ni, clr_all_q && req_i.ready, "ready during reset sweep")

endmodule
